// ===== hw/rtl/qph_pkg.sv =====
// ----------------------------------------------------------------------------
// qph_pkg
// Shared widths, codes and types for the quadratic-probe hash table.
// ----------------------------------------------------------------------------
package qph_pkg;

  localparam int CAPACITY   = 16384;
  localparam int SLOT_W     = $clog2(CAPACITY);
  localparam int CNT_W      = $clog2(CAPACITY + 1);
  localparam int KEY_W      = 31;
  localparam int TAG_W      = 64;
  localparam int MODE_W     = 2;
  localparam int SIZE_W     = 15;
  localparam int PROBES_W   = 15;
  localparam int SLOT_IDX_W = 14;
  localparam int DIV_CNT_W  = $clog2(KEY_W);

  localparam logic [SIZE_W-1:0] SIZE_RESET = 15'd10007;

  localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SEARCH = 2'd1;
  localparam logic [MODE_W-1:0] MODE_DELETE = 2'd2;

  typedef struct packed {
    logic             used;
    logic [KEY_W-1:0] key;
    logic [TAG_W-1:0] tag;
  } qph_entry_t;

  typedef struct packed {
    logic              we;
    logic [SLOT_W-1:0] addr;
    qph_entry_t        wdata;
  } qph_mem_req_t;

  typedef struct packed {
    logic              valid;
    logic              hit;
    logic [CNT_W-1:0]  probes;
    logic [SLOT_W-1:0] slot;
  } qph_result_t;

endpackage

// ===== hw/rtl/qph_modsub.sv =====
// ----------------------------------------------------------------------------
// qph_modsub
// Shared compare-subtract unit: reduces a value below twice the size.
// ----------------------------------------------------------------------------
module qph_modsub (
  input  logic [qph_pkg::CNT_W:0]   x,
  input  logic [qph_pkg::CNT_W-1:0] n,
  output logic [qph_pkg::CNT_W-1:0] y
);
  import qph_pkg::*;

  logic [CNT_W:0] diff;

  assign diff = x - {1'b0, n};
  assign y    = (x >= {1'b0, n}) ? diff[CNT_W-1:0] : x[CNT_W-1:0];

endmodule

// ===== hw/rtl/qph_store.sv =====
// ----------------------------------------------------------------------------
// qph_store
// Slot memory: one entry per slot, single port, registered read.
// ----------------------------------------------------------------------------
module qph_store (
  input  logic                  clk,
  input  qph_pkg::qph_mem_req_t req,
  output qph_pkg::qph_entry_t   rd_data
);
  import qph_pkg::*;

  qph_entry_t mem [CAPACITY];
  qph_entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.addr] <= req.wdata;
    end
    rd_data_r <= mem[req.addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ===== hw/rtl/qph_ctrl.sv =====
// ----------------------------------------------------------------------------
// qph_ctrl
// Sequencer: clear sweep, key mod size, then probes, each a memory read state followed by an evaluate state.
// ----------------------------------------------------------------------------
module qph_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [qph_pkg::MODE_W-1:0]  mode,
  input  logic [qph_pkg::KEY_W-1:0]   key,
  input  logic [qph_pkg::TAG_W-1:0]   tag,
  input  logic [qph_pkg::CNT_W-1:0]   n_in,
  output logic                        busy,
  output logic [qph_pkg::CNT_W:0]     ms_x,
  output logic [qph_pkg::CNT_W-1:0]   ms_n,
  input  logic [qph_pkg::CNT_W-1:0]   ms_y,
  output qph_pkg::qph_mem_req_t       mem_req,
  input  qph_pkg::qph_entry_t         mem_rd,
  output qph_pkg::qph_result_t        result
);
  import qph_pkg::*;

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_DIV   = 5'b00100,
    S_RD    = 5'b01000,
    S_EV    = 5'b10000
  } state_t;

  state_t                state_r, state_nxt;
  logic [SLOT_W-1:0]     clr_r, clr_nxt;
  logic                  valid_r, valid_nxt;
  logic [MODE_W-1:0]     mode_r, mode_nxt;
  logic [KEY_W-1:0]      key_r, key_nxt;
  logic [KEY_W-1:0]      key_sh_r, key_sh_nxt;
  logic [TAG_W-1:0]      tag_r, tag_nxt;
  logic [CNT_W-1:0]      n_r, n_nxt;
  logic [CNT_W-1:0]      rem_r, rem_nxt;
  logic [DIV_CNT_W-1:0]  div_cnt_r, div_cnt_nxt;
  logic [CNT_W-1:0]      d_r, d_nxt;
  logic [CNT_W-1:0]      s_r, s_nxt;
  logic [CNT_W-1:0]      i_r, i_nxt;
  logic                  hit_r, hit_nxt;
  logic [CNT_W-1:0]      probes_r, probes_nxt;
  logic [SLOT_W-1:0]     where_r, where_nxt;
  logic                  match;
  logic                  last;
  logic                  done;
  logic                  adv;

  assign match = mem_rd.used && (mem_rd.key == key_r) && (mem_rd.tag == tag_r);
  assign last  = (i_r == n_r - CNT_W'(1));
  assign ms_n  = n_r;

  always_comb begin
    state_nxt   = state_r;
    clr_nxt     = clr_r;
    mode_nxt    = mode_r;
    key_nxt     = key_r;
    key_sh_nxt  = key_sh_r;
    tag_nxt     = tag_r;
    n_nxt       = n_r;
    rem_nxt     = rem_r;
    div_cnt_nxt = div_cnt_r;
    d_nxt       = d_r;
    s_nxt       = s_r;
    i_nxt       = i_r;
    hit_nxt     = hit_r;
    probes_nxt  = probes_r;
    where_nxt   = where_r;
    ms_x        = '0;
    mem_req     = '{we: 1'b0, addr: s_r[SLOT_W-1:0], wdata: '0};
    done        = 1'b0;
    adv         = 1'b0;

    case (state_r)
      S_CLEAR: begin
        mem_req.we   = 1'b1;
        mem_req.addr = clr_r;
        clr_nxt      = clr_r + SLOT_W'(1);
        if (clr_r == SLOT_W'(CAPACITY - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          mode_nxt    = mode;
          key_nxt     = key;
          key_sh_nxt  = key;
          tag_nxt     = tag;
          n_nxt       = n_in;
          rem_nxt     = '0;
          div_cnt_nxt = '0;
          d_nxt       = '0;
          i_nxt       = '0;
          hit_nxt     = 1'b0;
          probes_nxt  = '0;
          where_nxt   = '0;
          state_nxt   = S_DIV;
        end
      end
      S_DIV: begin
        ms_x        = {rem_r, key_sh_r[KEY_W-1]};
        rem_nxt     = ms_y;
        key_sh_nxt  = key_sh_r << 1;
        div_cnt_nxt = div_cnt_r + DIV_CNT_W'(1);
        if (div_cnt_r == DIV_CNT_W'(KEY_W - 1)) begin
          s_nxt = ms_y;
          if (mode_r inside {MODE_INSERT, MODE_SEARCH, MODE_DELETE}) begin
            state_nxt = S_RD;
          end else begin
            done = 1'b1;
          end
        end
      end
      S_RD: begin
        ms_x      = (CNT_W+1)'(d_r) + (CNT_W+1)'(2);
        d_nxt     = (n_r == CNT_W'(1)) ? '0 : ms_y;
        state_nxt = S_EV;
      end
      S_EV: begin
        ms_x = (CNT_W+1)'(s_r) + (CNT_W+1)'(d_r);
        case (mode_r)
          MODE_INSERT: begin
            if (!mem_rd.used) begin
              mem_req.we    = 1'b1;
              mem_req.wdata = '{used: 1'b1, key: key_r, tag: tag_r};
              hit_nxt       = 1'b1;
              where_nxt     = s_r[SLOT_W-1:0];
              done          = 1'b1;
            end else if (last) begin
              done = 1'b1;
            end else begin
              adv = 1'b1;
            end
          end
          MODE_SEARCH: begin
            if (!mem_rd.used) begin
              done = 1'b1;
            end else begin
              probes_nxt = probes_r + CNT_W'(1);
              if (match) begin
                hit_nxt   = 1'b1;
                where_nxt = s_r[SLOT_W-1:0];
                done      = 1'b1;
              end else if (last) begin
                done = 1'b1;
              end else begin
                adv = 1'b1;
              end
            end
          end
          MODE_DELETE: begin
            if (match) begin
              mem_req.we = 1'b1;
              hit_nxt    = 1'b1;
            end
            if (last) begin
              done = 1'b1;
            end else begin
              adv = 1'b1;
            end
          end
          default: begin
            done = 1'b1;
          end
        endcase
        if (adv) begin
          s_nxt     = ms_y;
          i_nxt     = i_r + CNT_W'(1);
          state_nxt = S_RD;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    valid_nxt = done;
    if (done) begin
      state_nxt = S_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_r   <= '0;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r    <= mode_nxt;
    key_r     <= key_nxt;
    key_sh_r  <= key_sh_nxt;
    tag_r     <= tag_nxt;
    n_r       <= n_nxt;
    rem_r     <= rem_nxt;
    div_cnt_r <= div_cnt_nxt;
    d_r       <= d_nxt;
    s_r       <= s_nxt;
    i_r       <= i_nxt;
    hit_r     <= hit_nxt;
    probes_r  <= probes_nxt;
    where_r   <= where_nxt;
  end

  assign busy   = (state_r != S_IDLE);
  assign result = '{valid: valid_r, hit: hit_r, probes: probes_r, slot: where_r};

endmodule

// ===== hw/rtl/quadratic_probe_hash_table.sv =====
// ----------------------------------------------------------------------------
// quadratic_probe_hash_table
// Open-addressed hash table with quadratic probing (insert/search/delete).
// ----------------------------------------------------------------------------
// Usage:
//   Input: drive in_mode, in_key, in_name_tag and raise start; the item is
//   taken at a clock edge where start is high and busy is low.
//   Result: out_valid pulses for one cycle with out_hit, out_probes and
//   out_slot_index; the receiver cannot stall and must take it then.
//   Config: cfg_wr_en with cfg_wr_data writes table_size (use while idle).
// Per item: the key mod size is formed bit-serially on the shared
//   compare-subtract unit, then each probed slot takes a memory read state
//   plus an evaluate state on the single-port slot memory. Delete always
//   probes n_eff slots (table_size clamped to 1..16384). busy drops in the
//   cycle out_valid is shown.
// Reset: table_size returns to 10007 and a clearing pass frees all 16384
//   slots, one per cycle; busy stays high until the pass is done.
// ----------------------------------------------------------------------------
module quadratic_probe_hash_table (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic [qph_pkg::MODE_W-1:0]     in_mode,
  input  logic [qph_pkg::KEY_W-1:0]      in_key,
  input  logic [qph_pkg::TAG_W-1:0]      in_name_tag,
  output logic                           out_valid,
  output logic                           out_hit,
  output logic [qph_pkg::PROBES_W-1:0]   out_probes,
  output logic [qph_pkg::SLOT_IDX_W-1:0] out_slot_index,
  input  logic                           cfg_wr_en,
  input  logic [qph_pkg::SIZE_W-1:0]     cfg_wr_data
);
  import qph_pkg::*;

  logic [SIZE_W-1:0] table_size_r;
  logic [CNT_W-1:0]  n_eff;
  logic [CNT_W:0]    ms_x;
  logic [CNT_W-1:0]  ms_n;
  logic [CNT_W-1:0]  ms_y;
  qph_mem_req_t      mem_req;
  qph_entry_t        mem_rd;
  qph_result_t       result;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      table_size_r <= SIZE_RESET;
    end else if (cfg_wr_en) begin
      table_size_r <= cfg_wr_data;
    end
  end

  always_comb begin
    if (table_size_r == '0) begin
      n_eff = CNT_W'(1);
    end else if (32'(table_size_r) > 32'(CAPACITY)) begin
      n_eff = CNT_W'(CAPACITY);
    end else begin
      n_eff = CNT_W'(table_size_r);
    end
  end

  qph_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .mode    (in_mode),
    .key     (in_key),
    .tag     (in_name_tag),
    .n_in    (n_eff),
    .busy    (busy),
    .ms_x    (ms_x),
    .ms_n    (ms_n),
    .ms_y    (ms_y),
    .mem_req (mem_req),
    .mem_rd  (mem_rd),
    .result  (result)
  );

  qph_modsub u_modsub (
    .x (ms_x),
    .n (ms_n),
    .y (ms_y)
  );

  qph_store u_store (
    .clk     (clk),
    .req     (mem_req),
    .rd_data (mem_rd)
  );

  assign out_valid      = result.valid;
  assign out_hit        = result.hit;
  assign out_probes     = PROBES_W'(result.probes);
  assign out_slot_index = SLOT_IDX_W'(result.slot);

  a_result_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result shown while busy");

  a_accept_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted item did not start work");

  a_miss_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_hit) |-> (out_slot_index == '0))
    else $error("miss reports nonzero slot");

  a_clear_after_reset: assert property (@(posedge clk)
    (rst_n && $past(!rst_n)) |-> busy)
    else $error("clearing pass not running after reset");

endmodule
